@@ rtl/polite_broadcast_relay_controller_core_assert.svh @@
// Assertion macros used by the relay controller back end (pbr_back).
`ifndef POLITE_BROADCAST_RELAY_CONTROLLER_CORE_ASSERT_SVH
`define POLITE_BROADCAST_RELAY_CONTROLLER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PBR_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
`define PBR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define PBR_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define PBR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/pbr_pkg.sv @@
package pbr_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_HEARD = 2'd1;
    localparam logic [1:0] OP_SEND  = 2'd2;

    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_DELIVER = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    localparam logic [2:0] CFG_NODE_ID   = 3'd0;
    localparam logic [2:0] CFG_BCAST     = 3'd1;
    localparam logic [2:0] CFG_SLOT_MS   = 3'd2;
    localparam logic [2:0] CFG_GUARD_MS  = 3'd3;
    localparam logic [2:0] CFG_HOLD_MS   = 3'd4;

    localparam logic [31:0] BCAST_RESET = 32'hFFFF_FFFF;
    localparam logic [9:0]  SLOT_RESET  = 10'd10;
    localparam logic [15:0] GUARD_RESET = 16'd1000;
    localparam logic [15:0] HOLD_RESET  = 16'd5000;

    localparam logic [7:0]  DELAY_DONE  = 8'hFF;
    localparam logic [15:0] MS_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] sender_addr;
        logic [31:0] source_addr;
        logic [15:0] sequence_req;
        logic [31:0] dest_addr;
        logic [3:0]  buffer_tag;
        logic [8:0]  random_slots;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  out_tag;
        logic [31:0] out_source;
        logic [15:0] out_sequence;
        logic [31:0] out_dest;
    } t_out;

    typedef struct packed {
        logic [31:0] node_id;
        logic [31:0] broadcast_addr;
        logic [9:0]  slot_ms;
        logic [15:0] guard_ms;
        logic [15:0] hold_ms;
    } t_cfg;

    typedef enum logic [1:0] {
        CLS_TICK  = 2'd0,
        CLS_HEARD = 2'd1,
        CLS_SEND  = 2'd2
    } t_cls;

    typedef struct packed {
        t_cls        cls;
        logic [31:0] sender;
        logic [31:0] source;
        logic [15:0] seq;
        logic [31:0] dest;
        logic [3:0]  tag;
        logic [8:0]  rnd;
    } t_cmd;

endpackage

@@ rtl/pbr_front.sv @@
module pbr_front
    import pbr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_item,
    output logic o_busy,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_pop
);

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       n_wp, n_rp;
    logic [1:0] n_cnt;
    logic       c_push;
    t_cmd       c_cmd;

    assign o_busy      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_mem[r_rp];

    // unused op codes are taken and dropped here
    always_comb begin
        c_push       = 1'b0;
        c_cmd.cls    = CLS_TICK;
        c_cmd.sender = i_item.sender_addr;
        c_cmd.source = i_item.source_addr;
        c_cmd.seq    = i_item.sequence_req;
        c_cmd.dest   = i_item.dest_addr;
        c_cmd.tag    = i_item.buffer_tag;
        c_cmd.rnd    = i_item.random_slots;
        unique case (i_item.op)
            OP_TICK: begin
                c_push    = 1'b1;
                c_cmd.cls = CLS_TICK;
            end
            OP_HEARD: begin
                c_push    = 1'b1;
                c_cmd.cls = CLS_HEARD;
            end
            OP_SEND: begin
                c_push    = 1'b1;
                c_cmd.cls = CLS_SEND;
            end
            default: c_push = 1'b0;
        endcase
        c_push = c_push && i_start && !o_busy;
    end

    always_comb begin
        n_wp  = c_push ? ~r_wp : r_wp;
        n_rp  = i_cmd_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(c_push) - 2'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_mem[r_wp] <= c_cmd;
        end
    end

endmodule

@@ rtl/pbr_back.sv @@
`include "polite_broadcast_relay_controller_core_assert.svh"
module pbr_back
    import pbr_pkg::*;
#(
    parameter int RETX_ROUNDS     = 3,
    parameter int HEARD_LIMIT     = 4,
    parameter int SLOTS_PER_ROUND = 8,
    parameter int QUEUE_DEPTH     = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_res_valid,
    output t_out o_res
);

    localparam int RIW = $clog2(RETX_ROUNDS > 1 ? RETX_ROUNDS : 2);
    localparam int HIW = $clog2(HEARD_LIMIT > 1 ? HEARD_LIMIT : 2);
    localparam int HCW = $clog2(HEARD_LIMIT + 1);
    localparam int QIW = $clog2(QUEUE_DEPTH > 1 ? QUEUE_DEPTH : 2);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_HEARD = 5'b01000,
        ST_DROP  = 5'b10000
    } t_state;

    function automatic logic [7:0] f_delay(input logic [8:0] rnd, input int idx);
        logic [4:0] d;
        d = (idx < 3) ? 5'(rnd >> (3 * idx)) & 5'd7 : 5'd0;
        for (int k = 0; k < 8; k++) begin
            if (d >= 5'(SLOTS_PER_ROUND)) d = d - 5'(SLOTS_PER_ROUND);
        end
        return 8'(int'(d) + idx * SLOTS_PER_ROUND);
    endfunction

    function automatic logic [QIW-1:0] f_qnext(input logic [QIW-1:0] p);
        return (p == QIW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    t_state          r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    logic            r_busy, n_busy;
    logic            r_hold, n_hold;
    logic [15:0]     r_hcnt, n_hcnt;
    logic [15:0]     r_elapsed, n_elapsed;
    logic [31:0]     r_src, n_src;
    logic [31:0]     r_dst, n_dst;
    logic [15:0]     r_seq, n_seq;
    logic [3:0]      r_tag, n_tag;
    logic [7:0]      r_delay [RETX_ROUNDS];
    logic [7:0]      n_delay [RETX_ROUNDS];
    logic [31:0]     r_heard [HEARD_LIMIT];
    logic [31:0]     n_heard [HEARD_LIMIT];
    logic [HCW-1:0]  r_hlen, n_hlen;
    logic [31:0]     r_qdest [QUEUE_DEPTH];
    logic [15:0]     r_qseq  [QUEUE_DEPTH];
    logic [3:0]      r_qtag  [QUEUE_DEPTH];
    logic [8:0]      r_qrnd  [QUEUE_DEPTH];
    logic [QIW-1:0]  r_qhead, n_qhead;
    logic [QIW-1:0]  r_qtail, n_qtail;
    logic [QCW-1:0]  r_qcnt, n_qcnt;
    logic [15:0]     r_nseq, n_nseq;
    logic [RIW-1:0]  r_ri, n_ri;
    logic [HCW-1:0]  r_hj, n_hj;
    logic            r_res_valid, n_res_valid;
    t_out            r_res, n_res;

    logic            c_qwr;
    logic            c_start, c_first, c_tx, c_emit;
    logic [31:0]     c_st_src, c_st_dst;
    logic [15:0]     c_st_seq;
    logic [3:0]      c_st_tag;
    logic [8:0]      c_st_rnd;
    logic [15:0]     c_h;
    logic [17:0]     c_prod;
    t_out            c_out;

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign c_prod = 18'(r_delay[r_ri]) * 18'(i_cfg.slot_ms);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_busy      = r_busy;
        n_hold      = r_hold;
        n_hcnt      = r_hcnt;
        n_elapsed   = r_elapsed;
        n_src       = r_src;
        n_dst       = r_dst;
        n_seq       = r_seq;
        n_tag       = r_tag;
        n_delay     = r_delay;
        n_heard     = r_heard;
        n_hlen      = r_hlen;
        n_qhead     = r_qhead;
        n_qtail     = r_qtail;
        n_qcnt      = r_qcnt;
        n_nseq      = r_nseq;
        n_ri        = r_ri;
        n_hj        = r_hj;
        o_cmd_pop   = 1'b0;
        c_qwr       = 1'b0;
        c_start     = 1'b0;
        c_first     = 1'b0;
        c_tx        = 1'b0;
        c_emit      = 1'b0;
        c_st_src    = r_cmd.source;
        c_st_dst    = r_cmd.dest;
        c_st_seq    = r_cmd.seq;
        c_st_tag    = r_cmd.tag;
        c_st_rnd    = r_cmd.rnd;
        c_h         = r_hcnt;
        c_out       = r_res;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                unique case (r_cmd.cls)
                    CLS_TICK: begin
                        if (r_hold) begin
                            c_h    = (r_hcnt != MS_MAX) ? r_hcnt + 16'd1 : r_hcnt;
                            n_hcnt = c_h;
                            if (c_h >= i_cfg.hold_ms) n_hold = 1'b0;
                        end
                        if (r_busy) begin
                            n_elapsed = (r_elapsed != MS_MAX) ? r_elapsed + 16'd1 : r_elapsed;
                            n_ri      = '0;
                            n_state   = ST_ROUND;
                        end
                    end
                    CLS_HEARD: begin
                        if (!r_busy) begin
                            if (!r_hold) begin
                                c_start = 1'b1;
                                c_first = 1'b1;
                                n_hold  = 1'b1;
                                n_hcnt  = 16'd0;
                                if (r_cmd.dest == i_cfg.broadcast_addr ||
                                    r_cmd.dest == i_cfg.node_id) begin
                                    c_emit             = 1'b1;
                                    c_out.kind         = KIND_DELIVER;
                                    c_out.out_tag      = r_cmd.tag;
                                    c_out.out_source   = r_cmd.source;
                                    c_out.out_sequence = r_cmd.seq;
                                    c_out.out_dest     = r_cmd.dest;
                                end
                            end
                        end else if (r_cmd.source == r_src && r_cmd.seq == r_seq) begin
                            n_hj    = '0;
                            n_state = ST_HEARD;
                        end
                    end
                    CLS_SEND: begin
                        if (!r_busy) begin
                            c_start  = 1'b1;
                            c_st_src = i_cfg.node_id;
                            c_st_seq = r_nseq;
                            n_nseq   = r_nseq + 16'd1;
                            n_hold   = 1'b1;
                            n_hcnt   = 16'd0;
                            c_tx     = 1'b1;
                        end else if (r_qcnt == QCW'(QUEUE_DEPTH)) begin
                            c_emit             = 1'b1;
                            c_out.kind         = KIND_REJECT;
                            c_out.out_tag      = r_cmd.tag;
                            c_out.out_source   = i_cfg.node_id;
                            c_out.out_sequence = 16'd0;
                            c_out.out_dest     = r_cmd.dest;
                        end else begin
                            c_qwr   = 1'b1;
                            n_qtail = f_qnext(r_qtail);
                            n_qcnt  = r_qcnt + 1'b1;
                            n_nseq  = r_nseq + 16'd1;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_ROUND: begin
                // first pending round that is due fires, one round per cycle
                if (r_delay[r_ri] != DELAY_DONE && {2'b00, r_elapsed} > c_prod) begin
                    n_delay[r_ri] = DELAY_DONE;
                    c_tx          = 1'b1;
                    n_state       = ST_IDLE;
                end else if (r_ri == RIW'(RETX_ROUNDS - 1)) begin
                    n_state = (r_elapsed > i_cfg.guard_ms) ? ST_DROP : ST_IDLE;
                end else begin
                    n_ri = r_ri + 1'b1;
                end
            end
            ST_HEARD: begin
                if (r_hj == r_hlen) begin
                    if (r_hlen != HCW'(HEARD_LIMIT)) begin
                        n_heard[r_hlen[HIW-1:0]] = r_cmd.sender;
                        n_hlen  = r_hlen + 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_DROP;
                    end
                end else if (r_heard[r_hj[HIW-1:0]] == r_cmd.sender) begin
                    n_state = ST_IDLE;
                end else begin
                    n_hj = r_hj + 1'b1;
                end
            end
            ST_DROP: begin
                n_busy  = 1'b0;
                n_state = ST_IDLE;
                if (r_qcnt != '0) begin
                    c_start  = 1'b1;
                    c_st_src = i_cfg.node_id;
                    c_st_dst = r_qdest[r_qhead];
                    c_st_seq = r_qseq[r_qhead];
                    c_st_tag = r_qtag[r_qhead];
                    c_st_rnd = r_qrnd[r_qhead];
                    n_qhead  = f_qnext(r_qhead);
                    n_qcnt   = r_qcnt - 1'b1;
                    c_tx     = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (c_start) begin
            n_src     = c_st_src;
            n_dst     = c_st_dst;
            n_seq     = c_st_seq;
            n_tag     = c_st_tag;
            n_elapsed = 16'd0;
            n_busy    = 1'b1;
            n_hlen    = '0;
            for (int i = 0; i < RETX_ROUNDS; i++) begin
                n_delay[i] = f_delay(c_st_rnd, i);
            end
            for (int j = 0; j < HEARD_LIMIT; j++) begin
                n_heard[j] = 32'd0;
            end
        end
        if (c_first) begin
            n_heard[0] = r_cmd.sender;
            n_hlen     = HCW'(1);
        end
        if (c_tx) begin
            c_emit             = 1'b1;
            c_out.kind         = KIND_TX;
            c_out.out_tag      = n_tag;
            c_out.out_source   = n_src;
            c_out.out_sequence = n_seq;
            c_out.out_dest     = n_dst;
        end
        n_res_valid = c_emit;
        n_res       = c_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_busy      <= 1'b0;
            r_hold      <= 1'b0;
            r_hcnt      <= 16'd0;
            r_elapsed   <= 16'd0;
            r_src       <= 32'd0;
            r_dst       <= 32'd0;
            r_seq       <= 16'd0;
            r_tag       <= 4'd0;
            for (int i = 0; i < RETX_ROUNDS; i++) r_delay[i] <= DELAY_DONE;
            for (int j = 0; j < HEARD_LIMIT; j++) r_heard[j] <= 32'd0;
            r_hlen      <= '0;
            r_qhead     <= '0;
            r_qtail     <= '0;
            r_qcnt      <= '0;
            r_nseq      <= 16'd0;
            r_ri        <= '0;
            r_hj        <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_hold      <= n_hold;
            r_hcnt      <= n_hcnt;
            r_elapsed   <= n_elapsed;
            r_src       <= n_src;
            r_dst       <= n_dst;
            r_seq       <= n_seq;
            r_tag       <= n_tag;
            r_delay     <= n_delay;
            r_heard     <= n_heard;
            r_hlen      <= n_hlen;
            r_qhead     <= n_qhead;
            r_qtail     <= n_qtail;
            r_qcnt      <= n_qcnt;
            r_nseq      <= n_nseq;
            r_ri        <= n_ri;
            r_hj        <= n_hj;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_res <= n_res;
        if (c_qwr) begin
            r_qdest[r_qtail] <= r_cmd.dest;
            r_qseq[r_qtail]  <= r_nseq;
            r_qtag[r_qtail]  <= r_cmd.tag;
            r_qrnd[r_qtail]  <= r_cmd.rnd;
        end
    end

    `PBR_ASSERT_ALWAYS(a_qcnt_bound, i_clk, i_rst_n, r_qcnt <= QCW'(QUEUE_DEPTH))
    `PBR_ASSERT_ALWAYS(a_heard_bound, i_clk, i_rst_n, r_hlen <= HCW'(HEARD_LIMIT))
    `PBR_ASSERT_IMP(a_res_from_work, i_clk, i_rst_n, r_res_valid, $past(r_state) != ST_IDLE)
    `PBR_ASSERT_IMP(a_queue_needs_active, i_clk, i_rst_n, r_qcnt != '0, r_busy)

endmodule

@@ rtl/polite_broadcast_relay_controller_core.sv @@
// Polite broadcast relay controller. Commands (tick, packet heard, local send) are taken
// when start is high and busy is low; busy rises only when the two-entry command queue
// in front of the executor is full. Each command produces at most one result, shown on
// o_res for exactly one cycle with o_res_valid high; the result cannot be stalled. The
// executor takes a command only in ST_IDLE and runs it in ST_EXEC; a tick then scans
// retransmission rounds in ST_ROUND (up to RETX_ROUNDS), a repeat compares heard-list
// entries in ST_HEARD and then appends or decides the limit, and a drop uses ST_DROP.
// The user must write configuration through i_cfg_we/i_cfg_idx/i_cfg_data only while
// no command is in flight; the block itself does not enforce this.
module polite_broadcast_relay_controller_core
    import pbr_pkg::*;
#(
    parameter int RETX_ROUNDS     = 3,
    parameter int HEARD_LIMIT     = 4,
    parameter int SLOTS_PER_ROUND = 8,
    parameter int QUEUE_DEPTH     = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in         i_item,
    output logic        o_res_valid,
    output t_out        o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_cfg r_cfg, n_cfg;
    logic w_cmd_valid, w_cmd_pop;
    t_cmd w_cmd;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NODE_ID:  n_cfg.node_id        = i_cfg_data;
                CFG_BCAST:    n_cfg.broadcast_addr = i_cfg_data;
                CFG_SLOT_MS:  n_cfg.slot_ms        = i_cfg_data[9:0];
                CFG_GUARD_MS: n_cfg.guard_ms       = i_cfg_data[15:0];
                CFG_HOLD_MS:  n_cfg.hold_ms        = i_cfg_data[15:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_id        <= 32'd0;
            r_cfg.broadcast_addr <= BCAST_RESET;
            r_cfg.slot_ms        <= SLOT_RESET;
            r_cfg.guard_ms       <= GUARD_RESET;
            r_cfg.hold_ms        <= HOLD_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    pbr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .o_busy      (busy),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    pbr_back #(
        .RETX_ROUNDS     (RETX_ROUNDS),
        .HEARD_LIMIT     (HEARD_LIMIT),
        .SLOTS_PER_ROUND (SLOTS_PER_ROUND),
        .QUEUE_DEPTH     (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
